// ===== hdl/tmbc_pkg.sv =====
package tmbc_pkg;

  // Cell coordinates after the pixel-to-tile division, signed.
  localparam int COORD_W = 18;
  // Effective map dimensions, up to 256.
  localparam int DIM_W = 9;
  // Pixel edge values fed to the divider, signed.
  localparam int DIVIN_W = 17;
  // Result coordinate fields.
  localparam int FIELD_W = 12;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_BOX   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Divider tags: which box edge a quotient belongs to.
  localparam logic [1:0] TAG_LEFT  = 2'd0;
  localparam logic [1:0] TAG_RIGHT = 2'd1;
  localparam logic [1:0] TAG_TOP   = 2'd2;
  localparam logic [1:0] TAG_BOT   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAP_COLS = 1'b0;
  localparam logic CFG_MAP_ROWS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DWAIT,
    S_PREP,
    S_RD,
    S_EV,
    S_TEV,
    S_OUT
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [9:0]  box_w;
    logic [9:0]  box_h;
    logic [11:0] tile_col;
    logic [11:0] tile_row;
    logic        solid;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } dims_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         tag;
    logic [DIVIN_W-1:0] value;
  } div_req_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         tag;
    logic [COORD_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
  } result_t;

endpackage

// ===== hdl/tmbc_ram.sv =====
module tmbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tmbc_div.sv =====
module tmbc_div #(
  parameter int TILE_PIXELS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmbc_pkg::div_req_t req,
  output tmbc_pkg::div_rsp_t rsp
);
  import tmbc_pkg::*;

  // Reciprocal multiply; the estimate is low by at most one, fixed in the last stage.
  localparam int SH      = 17;
  localparam int MAG_W   = 16;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int Q_W     = DIVIN_W;
  localparam int QT_W    = Q_W + DIM_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SH) / TILE_PIXELS);
  localparam logic [DIM_W-1:0]   TDIV  = DIM_W'(TILE_PIXELS);

  logic               v1_r, v2_r, v3_r;
  logic [1:0]         tag1_r, tag2_r, tag3_r;
  logic               neg1_r, neg2_r;
  logic [MAG_W-1:0]   mag1_r, mag2_r;
  logic [PROD_W-1:0]  prod1_r;
  logic [Q_W-1:0]     q0_2_r;
  logic [QT_W-1:0]    qt2_r;
  logic [COORD_W-1:0] quo3_r;

  logic [DIVIN_W-1:0] abs_val;
  logic [Q_W-1:0]     q0;
  logic [QT_W-1:0]    rem;
  logic [Q_W-1:0]     qfix;

  always_comb begin
    abs_val = req.value[DIVIN_W-1] ? (~req.value + 1'b1) : req.value;
    q0      = prod1_r[SH+Q_W-1:SH];
    rem     = QT_W'(mag2_r) - qt2_r;
    qfix    = (rem >= QT_W'(TDIV)) ? (q0_2_r + 1'b1) : q0_2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    tag1_r  <= req.tag;
    neg1_r  <= req.value[DIVIN_W-1];
    mag1_r  <= abs_val[MAG_W-1:0];
    prod1_r <= PROD_W'(abs_val[MAG_W-1:0]) * PROD_W'(RECIP);
    tag2_r  <= tag1_r;
    neg2_r  <= neg1_r;
    mag2_r  <= mag1_r;
    q0_2_r  <= q0;
    qt2_r   <= QT_W'(q0) * QT_W'(TDIV);
    tag3_r  <= tag2_r;
    quo3_r  <= neg2_r ? (~COORD_W'(qfix) + 1'b1) : COORD_W'(qfix);
  end

  assign rsp.valid = v3_r;
  assign rsp.tag   = tag3_r;
  assign rsp.quo   = quo3_r;

endmodule

// ===== hdl/tmbc_ctrl.sv =====
module tmbc_ctrl #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  tmbc_pkg::item_t                                   item,
  input  tmbc_pkg::dims_t                                   dims,
  output tmbc_pkg::div_req_t                                div_req,
  input  tmbc_pkg::div_rsp_t                                div_rsp,
  output logic                                              ram_we,
  output logic [(GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1)-1:0] ram_waddr,
  output logic [GRID_COLS-1:0]                              ram_wdata,
  output logic                                              ram_re,
  output logic [(GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1)-1:0] ram_raddr,
  input  logic [GRID_COLS-1:0]                              ram_rdata,
  output logic                                              res_valid,
  input  logic                                              res_ready,
  output tmbc_pkg::result_t                                 res
);
  import tmbc_pkg::*;

  localparam int AW  = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
  localparam int CIW = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;

  state_t               state_r, state_nxt;
  item_t                it_r;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [COORD_W-1:0]   left_r, right_r, top_r, bot_r;
  logic [COORD_W-1:0]   row_r, row_nxt;
  logic [GRID_COLS-1:0] mask_r, mask_calc;
  logic [GRID_ROWS-1:0] row_vld_r;
  logic                 rvld_r;
  result_t              res_r, res_nxt;

  logic                 in_area;
  logic [DIVIN_W-1:0]   x_lo, x_hi, y_lo, y_hi;
  logic [COORD_W-1:0]   rows_s, cols_s;
  logic [GRID_COLS-1:0] word, hits, iso;
  logic [CIW-1:0]       hit_idx, col_idx;

  always_comb begin
    in_area = !item.tile_col[11] && !item.tile_row[11]
           && (item.tile_col < 12'(dims.cols)) && (item.tile_row < 12'(dims.rows));
    x_lo   = {it_r.box_x[15], it_r.box_x};
    y_lo   = {it_r.box_y[15], it_r.box_y};
    x_hi   = x_lo + DIVIN_W'(it_r.box_w) - 1'b1;
    y_hi   = y_lo + DIVIN_W'(it_r.box_h) - 1'b1;
    rows_s = COORD_W'(dims.rows);
    cols_s = COORD_W'(dims.cols);
    col_idx = it_r.tile_col[CIW-1:0];
    word    = rvld_r ? ram_rdata : '0;
    hits    = word & mask_r;
    iso     = hits & (~hits + 1'b1);
    hit_idx = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      if (iso[c]) begin
        hit_idx = hit_idx | CIW'(c);
      end
    end
    for (int c = 0; c < GRID_COLS; c++) begin
      mask_calc[c] = ($signed(COORD_W'(c)) >= $signed(left_r))
                  && ($signed(COORD_W'(c)) <= $signed(right_r))
                  && (DIM_W'(c) < dims.cols);
      ram_wdata[c] = (CIW'(c) == col_idx) ? it_r.solid : word[c];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = it_r.tile_row[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = row_r[AW-1:0];
    div_req.valid = 1'b0;
    div_req.tag   = cnt_r;
    unique case (cnt_r)
      TAG_LEFT:  div_req.value = x_lo;
      TAG_RIGHT: div_req.value = x_hi;
      TAG_TOP:   div_req.value = y_lo;
      default:   div_req.value = y_hi;
    endcase
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = item.tile_row[AW-1:0];
        if (in_valid) begin
          unique case (item.mode) inside
            MODE_WRITE, MODE_QUERY: begin
              if (in_area) begin
                ram_re    = 1'b1;
                state_nxt = S_TEV;
              end else if (item.mode == MODE_QUERY) begin
                res_nxt   = '{hit: 1'b1, col: '0, row: '0};
                state_nxt = S_OUT;
              end
            end
            MODE_BOX: begin
              if (item.box_w == '0 || item.box_h == '0) begin
                res_nxt   = '0;
                state_nxt = S_OUT;
              end else begin
                cnt_nxt   = TAG_LEFT;
                state_nxt = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        div_req.valid = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == TAG_BOT) begin
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_rsp.valid && div_rsp.tag == TAG_BOT) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        row_nxt = top_r;
        if ($signed(left_r) > $signed(right_r)) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (row_r[COORD_W-1] || ($signed(row_r) >= $signed(rows_s)) || left_r[COORD_W-1]) begin
          res_nxt   = '{hit: 1'b1, col: left_r[FIELD_W-1:0], row: row_r[FIELD_W-1:0]};
          state_nxt = S_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (hits != '0) begin
          res_nxt   = '{hit: 1'b1, col: FIELD_W'(hit_idx), row: row_r[FIELD_W-1:0]};
          state_nxt = S_OUT;
        end else if ($signed(right_r) >= $signed(cols_s)) begin
          res_nxt.hit = 1'b1;
          res_nxt.col = ($signed(left_r) > $signed(cols_s)) ? left_r[FIELD_W-1:0]
                                                            : cols_s[FIELD_W-1:0];
          res_nxt.row = row_r[FIELD_W-1:0];
          state_nxt   = S_OUT;
        end else if (row_r == bot_r) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_TEV: begin
        if (it_r.mode == MODE_WRITE) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          res_nxt   = '{hit: word[col_idx], col: '0, row: '0};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
    end
    if (in_valid && in_ready) begin
      it_r <= item;
    end
    if (ram_re) begin
      rvld_r <= row_vld_r[ram_raddr];
    end
    if (div_rsp.valid) begin
      case (div_rsp.tag)
        TAG_LEFT:  left_r  <= div_rsp.quo;
        TAG_RIGHT: right_r <= div_rsp.quo;
        TAG_TOP:   top_r   <= div_rsp.quo;
        default:   bot_r   <= div_rsp.quo;
      endcase
    end
    if (state_r == S_PREP) begin
      mask_r <= mask_calc;
    end
    row_r <= row_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_TEV && it_r.mode == MODE_WRITE))
    else $error("tile map written outside a tile write");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.valid |-> (state_r == S_DIV || state_r == S_DWAIT))
    else $error("divider result arrived outside the edge division phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (DIM_W'(ram_raddr) < dims.rows))
    else $error("tile map read outside the configured rows");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV || state_r == S_TEV) |-> $past(ram_re))
    else $error("row evaluated without a preceding read");

endmodule

// ===== hdl/tile_map_box_collision_top.sv =====
// Channel  Dir  Handshake          Payload
// in_      in   tvalid / tready    tuser: mode; tdata: box and tile fields
// out_     out  tvalid / tready    tuser: hit;  tdata: hit_col, hit_row
// cfg_     in   cfg_we             cfg_addr selects map_cols or map_rows
//
// Tile write: row read, then modify and write back.
// Tile query: row read, then evaluate, then hand over the result.
// Box query: accept, the left, right, top and bottom edge divisions, divider wait, mask setup, then a
// row read and an evaluation per scanned tile row, then result handover; a row off the map ends the scan unread.
// Reset leaves the row memory untouched; per-row valid flags make every row read as air.
// A result waiting on out_tready stalls the next result-producing transaction and all input behind it.
module tile_map_box_collision_top #(
  parameter int GRID_COLS   = 64,
  parameter int GRID_ROWS   = 32,
  parameter int TILE_PIXELS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  // box_x[15:0], box_y[31:16], box_w[41:32], box_h[51:42],
  // tile_col[63:52], tile_row[75:64], solid[76], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // hit
  output logic [23:0] out_tdata,  // hit_col[11:0], hit_row[23:12]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata
);
  import tmbc_pkg::*;

  localparam int AW = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;

  logic [6:0]           map_cols_r;
  logic [5:0]           map_rows_r;
  logic                 out_valid_r;
  result_t              out_res_r;

  item_t                item;
  dims_t                dims;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [GRID_COLS-1:0] ram_wdata, ram_rdata;
  logic                 res_valid, res_ready;
  result_t              res;

  // Unpack the input transaction.
  always_comb begin
    item.mode     = mode_t'(in_tuser);
    item.box_x    = in_tdata[15:0];
    item.box_y    = in_tdata[31:16];
    item.box_w    = in_tdata[41:32];
    item.box_h    = in_tdata[51:42];
    item.tile_col = in_tdata[63:52];
    item.tile_row = in_tdata[75:64];
    item.solid    = in_tdata[76];
  end

  // Saturate the configured size to the storage size.
  always_comb begin
    dims.cols = (DIM_W'(map_cols_r) > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS)
                                                        : DIM_W'(map_cols_r);
    dims.rows = (DIM_W'(map_rows_r) > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS)
                                                        : DIM_W'(map_rows_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= 7'd40;
      map_rows_r <= 6'd20;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAP_COLS: map_cols_r <= cfg_wdata;
        default:      map_rows_r <= cfg_wdata[5:0];
      endcase
    end
  end

  // Output register: load when empty or being drained, clear on a taken transaction.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.hit;
  assign out_tdata  = {out_res_r.row, out_res_r.col};

  tmbc_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmbc_div #(
    .TILE_PIXELS (TILE_PIXELS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tmbc_ctrl #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .dims      (dims),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
